>>> src/cec_pkg.sv
// Shared types, constants and calendar tables of the calendar epoch converter.
package cec_pkg;

  localparam logic [31:0] SecsMin     = 32'd60;
  localparam logic [31:0] SecsHour    = 32'd3600;
  localparam logic [31:0] SecsDay     = 32'd86400;
  localparam logic [31:0] SecsCommon  = 32'd31536000;
  localparam logic [31:0] SecsLeap    = 32'd31622400;
  localparam logic [31:0] SecsCentury = 32'd3155760000;
  localparam logic [31:0] EpochBaseRst = 32'd946684800;

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] MaxFullMonths = 4'd12;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        cout;
  } alu_rsp_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic        range_error;
  } res_t;

  function automatic logic [31:0] mon_secs(input logic [3:0] idx, input logic leap);
    logic [31:0] s;
    case (idx)
      4'd1:                      s = leap ? 32'd2505600 : 32'd2419200;
      4'd3, 4'd5, 4'd8, 4'd10:   s = 32'd2592000;
      default:                   s = 32'd2678400;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] year_secs(input logic [1:0] yr_lsb);
    return (yr_lsb == 2'd0) ? SecsLeap : SecsCommon;
  endfunction

endpackage

>>> src/cec_alu.sv
// Shared 32-bit add/subtract unit; cout is the borrow on subtract.
module cec_alu (
  input  cec_pkg::alu_req_t req_i,
  output cec_pkg::alu_rsp_t rsp_o
);
  import cec_pkg::*;

  logic [32:0] sum;

  always_comb begin
    if (req_i.sub) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.sum  = sum[31:0];
    rsp_o.cout = sum[32];
  end

endmodule

>>> src/cec_seq.sv
// Conversion sequencer: working registers and step control around the shared unit.
module cec_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [6:0]        in_year_i,
  input  logic [3:0]        in_month_i,
  input  logic [4:0]        in_day_i,
  input  logic [4:0]        in_hours_i,
  input  logic [5:0]        in_minutes_i,
  input  logic [5:0]        in_seconds_i,
  input  logic [31:0]       in_epoch_i,
  input  logic [31:0]       epoch_base_i,
  input  logic              take_i,
  output logic              done_o,
  output cec_pkg::res_t     res_o,
  output cec_pkg::alu_req_t alu_req_o,
  input  cec_pkg::alu_rsp_t alu_rsp_i
);
  import cec_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSEC  = 4'd1;
  localparam logic [3:0] S_DHRS  = 4'd2;
  localparam logic [3:0] S_DDAY  = 4'd3;
  localparam logic [3:0] S_DDM1  = 4'd4;
  localparam logic [3:0] S_DMON  = 4'd5;
  localparam logic [3:0] S_DYR   = 4'd6;
  localparam logic [3:0] S_DBASE = 4'd7;
  localparam logic [3:0] S_EOFF  = 4'd8;
  localparam logic [3:0] S_ECHK  = 4'd9;
  localparam logic [3:0] S_EYR   = 4'd10;
  localparam logic [3:0] S_EMON  = 4'd11;
  localparam logic [3:0] S_EDAY  = 4'd12;
  localparam logic [3:0] S_EHRS  = 4'd13;
  localparam logic [3:0] S_EMIN  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]  state_q, state_d;
  logic        op_q, op_d;
  logic        err_q, err_d;
  logic [31:0] acc_q, acc_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [3:0]  fm_q, fm_d;
  logic [6:0]  yr_q, yr_d;
  logic [3:0]  mo_q, mo_d;
  logic [4:0]  dy_q, dy_d;
  logic [4:0]  hr_q, hr_d;
  logic [5:0]  mi_q, mi_d;
  logic        no_borrow;

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_FIN);
  assign no_borrow  = !alu_rsp_i.cout;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    err_d   = err_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    fm_d    = fm_q;
    yr_d    = yr_q;
    mo_d    = mo_q;
    dy_d    = dy_q;
    hr_d    = hr_q;
    mi_d    = mi_q;
    alu_req_o.a   = acc_q;
    alu_req_o.b   = SecsDay;
    alu_req_o.sub = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_i;
          err_d = 1'b0;
          cnt_d = '0;
          if (in_month_i == 4'd0) begin
            fm_d = 4'd0;
          end else if (in_month_i > 4'd13) begin
            fm_d = MaxFullMonths;
          end else begin
            fm_d = in_month_i - 4'd1;
          end
          if (op_i) begin
            acc_d   = in_epoch_i;
            yr_d    = '0;
            mo_d    = '0;
            dy_d    = '0;
            hr_d    = '0;
            mi_d    = '0;
            state_d = S_EOFF;
          end else begin
            acc_d   = {26'd0, in_seconds_i};
            yr_d    = in_year_i;
            mo_d    = in_month_i;
            dy_d    = in_day_i;
            hr_d    = in_hours_i;
            mi_d    = in_minutes_i;
            state_d = S_DSEC;
          end
        end
      end
      S_DSEC: begin
        alu_req_o.b   = 32'(mi_q) * SecsMin;
        alu_req_o.sub = 1'b0;
        acc_d   = alu_rsp_i.sum;
        state_d = S_DHRS;
      end
      S_DHRS: begin
        alu_req_o.b   = 32'(hr_q) * SecsHour;
        alu_req_o.sub = 1'b0;
        acc_d   = alu_rsp_i.sum;
        state_d = S_DDAY;
      end
      S_DDAY: begin
        alu_req_o.b   = 32'(dy_q) * SecsDay;
        alu_req_o.sub = 1'b0;
        acc_d   = alu_rsp_i.sum;
        state_d = S_DDM1;
      end
      S_DDM1: begin
        acc_d   = alu_rsp_i.sum;
        cnt_d   = '0;
        state_d = S_DMON;
      end
      S_DMON: begin
        alu_req_o.b   = mon_secs(cnt_q[3:0], yr_q[1:0] == 2'd0);
        alu_req_o.sub = 1'b0;
        if (cnt_q[3:0] < fm_q) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 7'd1;
        end else begin
          cnt_d   = '0;
          state_d = S_DYR;
        end
      end
      S_DYR: begin
        alu_req_o.b   = year_secs(cnt_q[1:0]);
        alu_req_o.sub = 1'b0;
        if (cnt_q < yr_q) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 7'd1;
        end else begin
          state_d = S_DBASE;
        end
      end
      S_DBASE: begin
        alu_req_o.b   = epoch_base_i;
        alu_req_o.sub = 1'b0;
        acc_d   = alu_rsp_i.sum;
        state_d = S_FIN;
      end
      S_EOFF: begin
        alu_req_o.b = epoch_base_i;
        if (no_borrow) begin
          acc_d   = alu_rsp_i.sum;
          state_d = S_ECHK;
        end else begin
          err_d   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_ECHK: begin
        alu_req_o.b = SecsCentury;
        cnt_d = '0;
        if (no_borrow) begin
          err_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_EYR;
        end
      end
      S_EYR: begin
        alu_req_o.b = year_secs(cnt_q[1:0]);
        if (no_borrow) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 7'd1;
        end else begin
          yr_d    = cnt_q;
          state_d = S_EMON;
        end
      end
      S_EMON: begin
        alu_req_o.b = mon_secs(mo_q, yr_q[1:0] == 2'd0);
        if ((mo_q < LastMonth) && no_borrow) begin
          acc_d = alu_rsp_i.sum;
          mo_d  = mo_q + 4'd1;
        end else begin
          state_d = S_EDAY;
        end
      end
      S_EDAY: begin
        alu_req_o.b = SecsDay;
        if (no_borrow) begin
          acc_d = alu_rsp_i.sum;
          dy_d  = dy_q + 5'd1;
        end else begin
          state_d = S_EHRS;
        end
      end
      S_EHRS: begin
        alu_req_o.b = SecsHour;
        if (no_borrow) begin
          acc_d = alu_rsp_i.sum;
          hr_d  = hr_q + 5'd1;
        end else begin
          state_d = S_EMIN;
        end
      end
      S_EMIN: begin
        alu_req_o.b = SecsMin;
        if (no_borrow) begin
          acc_d = alu_rsp_i.sum;
          mi_d  = mi_q + 6'd1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    if (!op_q) begin
      res_o.epoch = acc_q;
    end else if (err_q) begin
      res_o.range_error = 1'b1;
    end else begin
      res_o.year    = yr_q;
      res_o.month   = mo_q + 4'd1;
      res_o.day     = dy_q + 5'd1;
      res_o.hours   = hr_q;
      res_o.minutes = mi_q;
      res_o.seconds = acc_q[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    fm_q  <= fm_d;
    yr_q  <= yr_d;
    mo_q  <= mo_d;
    dy_q  <= dy_d;
    hr_q  <= hr_d;
    mi_q  <= mi_d;
  end

endmodule

>>> src/calendar_epoch_converter.sv
// Top level of the calendar epoch converter: register port, sequencer and output register.
//
//   channel   direction  handshake                  content
//   input     in         in_valid_i / in_ready_o    op, date fields, epoch
//   output    out        out_valid_o / out_ready_i  epoch, date fields, range error
//   config    in         psel/penable/pwrite/pready epoch_base at byte address 0
//
// Date to epoch adds minutes, hours and days, takes off one day, then adds each full month,
// each year and epoch_base. Epoch to date stops early on a range error, else steps
// through years, months, days, hours and minutes, paced by the one shared 32-bit adder.
// A new word is taken only when the sequencer is idle; a finished word waits
// in the output register, and the sequencer holds its result while that register is full.
// Reset loads epoch_base with 2000-01-01 in Unix seconds and empties the output.
module calendar_epoch_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [6:0]  in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [4:0]  in_hours_i,
  input  logic [5:0]  in_minutes_i,
  input  logic [5:0]  in_seconds_i,
  input  logic [31:0] in_epoch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_epoch_o,
  output logic [6:0]  out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hours_o,
  output logic [5:0]  out_minutes_o,
  output logic [5:0]  out_seconds_o,
  output logic        range_error_o
);
  import cec_pkg::*;

  logic [31:0] base_q;
  logic        out_valid_q;
  res_t        out_q;
  res_t        res;
  logic        done;
  logic        take;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= EpochBaseRst;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      base_q <= pwdata;
    end
  end

  cec_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  cec_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .in_year_i    (in_year_i),
    .in_month_i   (in_month_i),
    .in_day_i     (in_day_i),
    .in_hours_i   (in_hours_i),
    .in_minutes_i (in_minutes_i),
    .in_seconds_i (in_seconds_i),
    .in_epoch_i   (in_epoch_i),
    .epoch_base_i (base_q),
    .take_i       (take),
    .done_o       (done),
    .res_o        (res),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp)
  );

  assign take = done && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_epoch_o   = out_q.epoch;
  assign out_year_o    = out_q.year;
  assign out_month_o   = out_q.month;
  assign out_day_o     = out_q.day;
  assign out_hours_o   = out_q.hours;
  assign out_minutes_o = out_q.minutes;
  assign out_seconds_o = out_q.seconds;
  assign range_error_o = out_q.range_error;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took a word while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> out_epoch_o == 32'd0 && out_month_o == 4'd0 &&
      out_day_o == 5'd0 && out_year_o == 7'd0)
    else $error("range error word carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_month_o != 4'd0 |-> out_epoch_o == 32'd0 && !range_error_o)
    else $error("date word carries an epoch or an error");

endmodule
